FILE: src/tilt_angle_kalman_filter_top_defines.svh
// assertion macros for the tilt angle kalman filter
// used by the top level only
`ifndef TILT_ANGLE_KALMAN_FILTER_TOP_DEFINES_SVH
`define TILT_ANGLE_KALMAN_FILTER_TOP_DEFINES_SVH
`ifndef SYNTH
`define TAKF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TAKF_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAKF_ASSERT(lbl, clk, rst, prop, msg)
`define TAKF_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

FILE: src/takf_pkg.sv
// shared types and constants for the tilt angle kalman filter
// no dependencies
package takf_pkg;
   localparam int NumChannelsDef = 2;
   localparam int DataWidthDef = 32;
   localparam int RegW = 31;
   localparam int FieldW = 32;
   localparam logic [RegW-1:0] QaReset = 31'd1073742;
   localparam logic [RegW-1:0] QbReset = 31'd3221225;
   localparam logic [RegW-1:0] RReset = 31'd536870912;
   localparam logic [RegW-1:0] DtReset = 31'd10737418;
   localparam logic signed [31:0] Q30One = 32'sd1073741824;

   localparam logic [1:0] RegQa = 2'd0;
   localparam logic [1:0] RegQb = 2'd1;
   localparam logic [1:0] RegR = 2'd2;
   localparam logic [1:0] RegDt = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_PRED, ST_EST, ST_P00, ST_P01, ST_P10, ST_P11,
      ST_DEN, ST_DIV0, ST_DIV1, ST_INN, ST_ANG, ST_BIAS,
      ST_U10, ST_U00, ST_U11, ST_U01, ST_WB, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic signed [33:0] num;
      logic signed [33:0] den;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic signed [31:0] quo;
   } div_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7fffffff;
      else if (x < -66'sd2147483648) return 32'sh80000000;
      else return x[31:0];
   endfunction
endpackage

FILE: src/takf_div.sv
// serial restoring divider for the gain computation, one quotient bit a cycle
// uses takf_pkg; result clamped to -1.0 .. +1.0 in q2.30
module takf_div import takf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [33:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;
   logic [63:0] numa;
   logic [64:0] sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      numa = '0;
      trial = {rem_ff, quo_ff[63]} - {31'd0, den_ff};
      rsp.done = busy_ff && (cnt_ff == 7'd0);
      sq = '0;
      if (req.start) begin
         numa = req.num[33] ? 64'(-{{30{req.num[33]}}, req.num}) << 30
                            : 64'({30'd0, req.num}) << 30;
         busy_in = 1'b1;
         cnt_in = 7'd64;
         rem_in = '0;
         quo_in = numa;
         den_in = req.den;
         neg_in = req.num[33];
      end else if (busy_ff) begin
         if (cnt_ff != 7'd0) begin
            if (!trial[64]) begin
               rem_in = trial[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], quo_ff[63]};
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff - 7'd1;
         end else begin
            busy_in = 1'b0;
         end
      end
      if (quo_ff > 64'd1073741824) sq = 65'sd1073741824;
      else sq = {1'b0, quo_ff};
      if (neg_ff) sq = -sq;
      rsp.quo = sq[31:0];
   end
endmodule

FILE: src/takf_mul.sv
// shared signed multiplier with q30 rounding, registered result
// uses takf_pkg
module takf_mul import takf_pkg::*; (
   input  logic                clock,
   input  logic signed [33:0]  mul_a,
   input  logic signed [31:0]  mul_b,
   output logic signed [35:0]  mul_p
);
   logic signed [65:0] prod;
   logic signed [35:0] mul_p_ff;
   always_comb prod = 66'(mul_a) * 66'(mul_b) + 66'sd536870912;
   always_ff @(posedge clock) mul_p_ff <= prod[65:30];
   assign mul_p = mul_p_ff;
endmodule

FILE: src/tilt_angle_kalman_filter_top.sv
// Tilt angle kalman filter, two states per channel. A request is taken only in idle and
// its response is formed by five set-up steps on the shared 34x32 multiplier, two
// restoring divides for the gains, then ten steps of correction, write-back and output
// (the divides are skipped when the gain denominator is not positive). A new request is
// taken only once the sequencer is back in idle; a stalled response holds the sequencer
// in its output step. Not ready while busy.
// uses takf_pkg, takf_mul, takf_div and the assertion header
`include "tilt_angle_kalman_filter_top_defines.svh"
module tilt_angle_kalman_filter_top import takf_pkg::*; #(
   parameter int NUM_CHANNELS = NumChannelsDef,
   parameter int DATA_WIDTH = DataWidthDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // accel_angle, gyro_rate
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // filtered_angle, bias_estimate
   output logic        rsp_tuser,   // channel
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int SW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
   localparam logic signed [65:0] SatHi = (66'sd1 <<< (SW - 1)) - 66'sd1;
   localparam logic signed [65:0] SatLo = -(66'sd1 <<< (SW - 1));

   function automatic logic signed [31:0] satw(input logic signed [65:0] x);
      logic signed [65:0] y;
      y = x;
      if (y > SatHi) y = SatHi;
      if (y < SatLo) y = SatLo;
      return y[31:0];
   endfunction

   logic [RegW-1:0] qa_ff, qb_ff, r_ff, dt_ff;
   logic signed [31:0] ang_ff [NUM_CHANNELS];
   logic signed [31:0] bias_ff [NUM_CHANNELS];
   logic signed [31:0] c00_ff [NUM_CHANNELS];
   logic signed [31:0] c01_ff [NUM_CHANNELS];
   logic signed [31:0] c10_ff [NUM_CHANNELS];
   logic signed [31:0] c11_ff [NUM_CHANNELS];

   state_type st_ff, st_in;
   logic [CW-1:0] ch_ff, ch_in;
   logic signed [31:0] acc_ff, acc_in, rate_ff, rate_in;
   logic signed [31:0] est_ff, est_in, p00_ff, p00_in, p01_ff, p01_in;
   logic signed [31:0] p10_ff, p10_in, p11_ff, p11_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, na_ff, na_in, nb_ff, nb_in;
   logic signed [33:0] inn_ff, inn_in;
   logic [63:0] out_ff;
   logic out_ch_ff;
   logic vld_ff, vld_in, wb;
   logic signed [33:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [35:0] mul_p;
   logic signed [33:0] den;
   div_req_type dreq;
   div_rsp_type drsp;
   logic modeok;

   takf_mul u_mul (.clock(clock), .mul_a(mul_a), .mul_b(mul_b), .mul_p(mul_p));
   takf_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   assign modeok = 32'(req_tuser) < NUM_CHANNELS;
   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = out_ff;
   assign rsp_tuser = out_ch_ff;
   assign den = 34'(p00_ff) + 34'(signed'({1'b0, r_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         vld_ff <= 1'b0;
         qa_ff <= QaReset;
         qb_ff <= QbReset;
         r_ff <= RReset;
         dt_ff <= DtReset;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            ang_ff[c] <= '0;
            bias_ff[c] <= '0;
            c00_ff[c] <= satw(66'(Q30One));
            c01_ff[c] <= '0;
            c10_ff[c] <= '0;
            c11_ff[c] <= satw(66'(Q30One));
         end
      end else begin
         st_ff <= st_in;
         vld_ff <= vld_in;
         if (csr_we) begin
            case (csr_index)
               RegQa: qa_ff <= csr_wdata;
               RegQb: qb_ff <= csr_wdata;
               RegR: r_ff <= csr_wdata;
               RegDt: dt_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (wb) begin
            ang_ff[ch_ff] <= na_ff;
            bias_ff[ch_ff] <= nb_ff;
            c00_ff[ch_ff] <= p00_ff;
            c01_ff[ch_ff] <= p01_ff;
            c10_ff[ch_ff] <= p10_ff;
            c11_ff[ch_ff] <= p11_ff;
         end
      end
      ch_ff <= ch_in; acc_ff <= acc_in; rate_ff <= rate_in; est_ff <= est_in;
      p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in; p11_ff <= p11_in;
      k0_ff <= k0_in; k1_ff <= k1_in; na_ff <= na_in; nb_ff <= nb_in;
      inn_ff <= inn_in;
      if ((st_ff == ST_OUT) && (!vld_ff || rsp_tready)) begin
         out_ff <= {nb_ff, na_ff};
         out_ch_ff <= 1'(ch_ff);
      end
   end

   // each multiplier step issues one product, takes the one issued in the step before, or both
   always_comb begin
      st_in = st_ff; vld_in = vld_ff; wb = 1'b0;
      ch_in = ch_ff; acc_in = acc_ff; rate_in = rate_ff; est_in = est_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      k0_in = k0_ff; k1_in = k1_ff; na_in = na_ff; nb_in = nb_ff; inn_in = inn_ff;
      mul_a = '0; mul_b = '0;
      dreq.start = 1'b0; dreq.num = '0; dreq.den = den;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready && modeok) begin
               ch_in = CW'(req_tuser);
               acc_in = req_tdata[31:0];
               rate_in = req_tdata[63:32];
               st_in = ST_PRED;
            end
         end
         ST_PRED: begin
            p00_in = c00_ff[ch_ff]; p01_in = c01_ff[ch_ff];
            p10_in = c10_ff[ch_ff]; p11_in = c11_ff[ch_ff];
            mul_a = 34'(rate_ff) - 34'(bias_ff[ch_ff]);
            mul_b = 32'(dt_ff);
            st_in = ST_EST;
         end
         ST_EST: begin
            est_in = satw(66'(ang_ff[ch_ff]) + 66'(mul_p));
            mul_a = 34'(p01_ff) + 34'(p10_ff);
            mul_b = 32'(dt_ff);
            st_in = ST_P00;
         end
         ST_P00: begin
            p00_in = satw(66'(p00_ff) + 66'(signed'({1'b0, qa_ff})) - 66'(mul_p));
            mul_a = 34'(p11_ff);
            mul_b = 32'(dt_ff);
            st_in = ST_P01;
         end
         ST_P01: begin
            p01_in = satw(66'(p01_ff) - 66'(mul_p));
            p10_in = satw(66'(p10_ff) - 66'(mul_p));
            p11_in = satw(66'(p11_ff) + 66'(signed'({1'b0, qb_ff})));
            st_in = ST_DEN;
         end
         ST_DEN: begin
            if (den <= 34'sd0) begin
               k0_in = '0; k1_in = '0;
               st_in = ST_INN;
            end else begin
               dreq.start = 1'b1; dreq.num = 34'(p00_ff);
               st_in = ST_DIV0;
            end
         end
         ST_DIV0: begin
            if (drsp.done) begin
               k0_in = drsp.quo;
               dreq.start = 1'b1; dreq.num = 34'(p10_ff);
               st_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (drsp.done) begin
               k1_in = drsp.quo;
               st_in = ST_INN;
            end
         end
         ST_INN: begin
            inn_in = 34'(acc_ff) - 34'(est_ff);
            st_in = ST_P10;
         end
         ST_P10: begin
            mul_a = inn_ff; mul_b = k0_ff;
            st_in = ST_ANG;
         end
         ST_ANG: begin
            na_in = satw(66'(est_ff) + 66'(mul_p));
            mul_a = inn_ff; mul_b = k1_ff;
            st_in = ST_BIAS;
         end
         ST_BIAS: begin
            nb_in = satw(66'(bias_ff[ch_ff]) + 66'(mul_p));
            mul_a = 34'(p00_ff); mul_b = k1_ff;
            st_in = ST_U10;
         end
         ST_U10: begin
            p10_in = satw(66'(p10_ff) - 66'(mul_p));
            mul_a = 34'(p00_ff); mul_b = k0_ff;
            st_in = ST_U00;
         end
         ST_U00: begin
            p00_in = satw(66'(p00_ff) - 66'(mul_p));
            mul_a = 34'(p01_ff); mul_b = k1_ff;
            st_in = ST_U11;
         end
         ST_U11: begin
            p11_in = satw(66'(p11_ff) - 66'(mul_p));
            mul_a = 34'(p01_ff); mul_b = k0_ff;
            st_in = ST_U01;
         end
         ST_U01: begin
            p01_in = satw(66'(p01_ff) - 66'(mul_p));
            st_in = ST_WB;
         end
         ST_WB: begin
            wb = 1'b1;
            st_in = ST_OUT;
         end
         ST_OUT: begin
            if (!vld_ff || rsp_tready) begin
               vld_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   `TAKF_ASSERT(a_no_accept_busy, clock, reset, (st_ff != ST_IDLE) |-> !req_tready, "ready while busy")
   `TAKF_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "response dropped")
   `TAKF_ASSERT(a_div_idle, clock, reset, (st_ff == ST_IDLE) |-> !dreq.start, "divide outside step")
endmodule

FILE: verif/tb_checker.sv
// checker for the tilt angle kalman filter: predicts each result from accepted requests
// and compares it with the response channel; depends on takf_pkg
`timescale 1ns / 100ps
module tb_checker import takf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [30:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   typedef struct packed {
      logic               channel;
      logic signed [31:0] angle;
      logic signed [31:0] bias;
   } filt_result_type;

   logic [30:0] qa, qb, rn, dt;
   logic signed [31:0] ang_st[2], bias_st[2], p00_st[2], p01_st[2], p10_st[2], p11_st[2];
   filt_result_type expected_q[$];

   function automatic longint clip(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint kgain(longint num, longint den);
      longint k;
      if (den <= 0) return 0;
      k = (num * (64'sd1 <<< 30)) / den;
      if (k > (64'sd1 <<< 30)) k = 64'sd1 <<< 30;
      if (k < -(64'sd1 <<< 30)) k = -(64'sd1 <<< 30);
      return k;
   endfunction

   task automatic filter_step(input logic ch, input logic signed [31:0] acc,
                              input logic signed [31:0] rate);
      longint est, p00, p01, p10, p11, k0, k1, inn, na, nb;
      filt_result_type r;
      est = clip(longint'(ang_st[ch]) +
                 qmul(longint'(rate) - longint'(bias_st[ch]), longint'(dt)));
      p00 = longint'(p00_st[ch]); p01 = longint'(p01_st[ch]);
      p10 = longint'(p10_st[ch]); p11 = longint'(p11_st[ch]);
      p00 = clip(p00 + longint'(qa) - qmul(p01 + p10, longint'(dt)));
      p01 = clip(p01 - qmul(p11, longint'(dt)));
      p10 = clip(p10 - qmul(p11, longint'(dt)));
      p11 = clip(p11 + longint'(qb));
      k0 = kgain(p00, p00 + longint'(rn));
      k1 = kgain(p10, p00 + longint'(rn));
      inn = longint'(acc) - est;
      na = clip(est + qmul(k0, inn));
      nb = clip(longint'(bias_st[ch]) + qmul(k1, inn));
      p10 = clip(p10 - qmul(k1, p00));
      p00 = clip(p00 - qmul(k0, p00));
      p11 = clip(p11 - qmul(k1, p01));
      p01 = clip(p01 - qmul(k0, p01));
      ang_st[ch] = 32'(na); bias_st[ch] = 32'(nb);
      p00_st[ch] = 32'(p00); p01_st[ch] = 32'(p01);
      p10_st[ch] = 32'(p10); p11_st[ch] = 32'(p11);
      r.channel = ch; r.angle = 32'(na); r.bias = 32'(nb);
      expected_q.push_back(r);
   endtask

   always @(posedge clock) begin
      filt_result_type e;
      logic bad;
      bad = 1'b0;
      if (reset) begin
         qa <= QaReset; qb <= QbReset; rn <= RReset; dt <= DtReset;
         for (int c = 0; c < 2; c++) begin
            ang_st[c] = 0; bias_st[c] = 0; p00_st[c] = Q30One;
            p01_st[c] = 0; p10_st[c] = 0; p11_st[c] = Q30One;
         end
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result, channel %0d", rsp_tuser);
               bad = 1'b1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_tuser !== e.channel) begin
                  $error("channel: expected %0d actual %0d", e.channel, rsp_tuser);
                  bad = 1'b1;
               end
               if ($signed(rsp_tdata[31:0]) !== e.angle) begin
                  $error("filtered_angle: expected %0d actual %0d", e.angle,
                         $signed(rsp_tdata[31:0]));
                  bad = 1'b1;
               end
               if ($signed(rsp_tdata[63:32]) !== e.bias) begin
                  $error("bias_estimate: expected %0d actual %0d", e.bias,
                         $signed(rsp_tdata[63:32]));
                  bad = 1'b1;
               end
            end
         end
         if (bad) fail_count <= fail_count + 1;
         if (req_tvalid && req_tready)
            filter_step(req_tuser, req_tdata[31:0], req_tdata[63:32]);
         if (csr_we) begin
            case (csr_index)
               RegQa: qa <= csr_wdata;
               RegQb: qb <= csr_wdata;
               RegR:  rn <= csr_wdata;
               RegDt: dt <= csr_wdata;
               default: ;
            endcase
         end
         pending <= expected_q.size();
      end
   end
endmodule

FILE: verif/tb_top.sv
// testbench top for the tilt angle kalman filter: drives requests, settings and stalls
// depends on takf_pkg, tb_checker and the filter rtl
`timescale 1ns / 100ps
module tb_top import takf_pkg::*;;
   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, req_tready, req_tuser = 0;
   logic [63:0] req_tdata = 0;
   logic        rsp_tvalid, rsp_tready = 0, rsp_tuser;
   logic [63:0] rsp_tdata;
   logic        csr_we = 0;
   logic [1:0]  csr_index = 0;
   logic [30:0] csr_wdata = 0;
   int          fail_count, pending, quiet;
   bit          calm = 0;

   localparam int WatchLimit = 20000;

   tilt_angle_kalman_filter_top dut (.*);
   tb_checker chk (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(negedge clock)
      rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 7);

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > WatchLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_request(input logic ch, input logic [31:0] acc, input logic [31:0] rate);
      while (!calm && $urandom_range(99) < 7) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1; req_tuser <= ch; req_tdata <= {rate, acc};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_setting(input logic [1:0] idx, input logic [30:0] val);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
      @(negedge clock);
   endtask

   task automatic settle;
      req_tvalid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_angle();
      case ($urandom_range(9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom();
         default: return 32'($signed($urandom_range(180 << 16)) - (90 << 16));
      endcase
   endfunction

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++)
         send_request(1'($urandom_range(1)), pick_angle(),
                      ($urandom_range(7) == 0) ? $urandom() :
                      32'($signed($urandom_range(400 << 16)) - (200 << 16)));
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      send_request(0, 0, 0);
      send_request(1, 32'h7fffffff, 32'h7fffffff);
      send_request(0, 32'h80000000, 32'h80000000);
      send_request(1, 32'h80000000, 32'h7fffffff);
      send_request(0, 32'h7fffffff, 32'h80000000);
      send_request(1, 32'hffffffff, 32'h00000001);
      send_request(0, 30 << 16, 5 << 16);
      send_request(1, -(45 << 16), -(3 << 16));
      settle();
      // extremes of every setting
      write_setting(RegQa, 31'h7fffffff);
      write_setting(RegQb, 31'h7fffffff);
      write_setting(RegR, 31'd1);
      write_setting(RegDt, 31'd1073741824);
      for (int i = 0; i < 8; i++) send_request(i[0], pick_angle(), $urandom());
      settle();
      write_setting(RegQa, 31'd0);
      write_setting(RegQb, 31'd0);
      write_setting(RegR, 31'h7fffffff);
      write_setting(RegDt, 31'd1);
      for (int i = 0; i < 6; i++) send_request(i[0], pick_angle(), $urandom());
      settle();
      write_setting(RegQa, QaReset);
      write_setting(RegQb, QbReset);
      write_setting(RegR, RReset);
      write_setting(RegDt, DtReset);
      calm = 1;
      random_phase(200);
      calm = 0;
      random_phase(500);
      settle();
      write_setting(RegQa, 31'($urandom_range(1 << 24)));
      write_setting(RegQb, 31'($urandom_range(1 << 24)));
      write_setting(RegR, 31'($urandom_range(1 << 30, 1)));
      write_setting(RegDt, 31'($urandom_range(1 << 28, 1)));
      random_phase(350);
      settle();
      write_setting(RegQa, 31'($urandom()));
      write_setting(RegQb, 31'($urandom()));
      write_setting(RegR, 31'($urandom_range(31'h7fffffff, 1)));
      write_setting(RegDt, 31'($urandom_range(1 << 30, 1)));
      random_phase(330);
      settle();
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
